FILE: hw/rtl/pcp_pkg.sv
// shared types and constants for the polyline closest point block
package pcp_pkg;

  localparam int unsigned CoordW      = 24;
  localparam int unsigned DirW        = 16;
  localparam int unsigned ParamW      = 17;
  localparam int unsigned DistW       = 48;
  localparam int unsigned ArcW        = 40;
  localparam int unsigned CfgIdxW     = 1;
  localparam int unsigned CfgDataW    = 24;
  localparam int unsigned CoordFracBitsDef = 8;

  localparam logic [CfgIdxW-1:0] CfgQueryX = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgQueryY = 1'b1;

  localparam logic signed [DirW-1:0] OneDir = 16'sd16384;
  localparam logic [DistW-1:0]        DistMax = '1;
  localparam logic [ArcW-1:0]         ArcMax  = '1;

  typedef struct packed {
    logic                     found;
    logic signed [CoordW-1:0] closest_x;
    logic signed [CoordW-1:0] closest_y;
    logic signed [DirW-1:0]   tangent_x;
    logic signed [DirW-1:0]   tangent_y;
    logic [ParamW-1:0]        edge_param;
    logic [DistW-1:0]         distance_sq;
  } result_t;

  typedef struct packed {
    logic signed [CoordW-1:0] vertex_x;
    logic signed [CoordW-1:0] vertex_y;
    logic                     last_vertex;
  } vertex_t;

  // request to and answer from the shared divide / root unit
  typedef struct packed {
    logic        start;
    logic        is_sqrt;
    logic [63:0] num;
    logic [63:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quo;
    logic [63:0] rem;
  } div_rsp_t;

endpackage

FILE: hw/rtl/pcp_if.sv
// valid / ready channel carrying one word
interface pcp_if #(parameter type word_t = logic) ();
  logic  valid;
  logic  ready;
  word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/polyline_closest_point.sv
// polyline closest point: top level
// work per vertex: a vertex that opens a polyline uses no divide; a segment uses the root and, unless
// degenerate, two divides for its tangent, one more when the projection needs a divide (bit-serial unit)
// the last vertex may add one divide for the edge parameter before the result word is registered
// throughput: one vertex at a time; ready stays low while a vertex is in work or a word waits
// reset: asynchronous active low, clears query registers and all polyline state
module polyline_closest_point
  import pcp_pkg::*;
#(
  parameter int unsigned COORD_FRAC_BITS = CoordFracBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  pcp_if.sink                 in_if,
  pcp_if.source               out_if
);
  logic signed [CoordW-1:0] qx_q, qy_q;
  div_req_t req;
  div_rsp_t rsp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qx_q <= '0; qy_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgQueryX: qx_q <= cfg_data_i;
        CfgQueryY: qy_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  pcp_seq #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_seq (
    .clk_i, .rst_ni, .qx_i(qx_q), .qy_i(qy_q),
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready), .in_data_i(in_if.data),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready), .out_data_o(out_if.data),
    .div_req_o(req), .div_rsp_i(rsp)
  );

  pcp_divsqrt u_div (.clk_i, .rst_ni, .req_i(req), .rsp_o(rsp));
endmodule

FILE: hw/rtl/pcp_divsqrt.sv
// iterative radix-2 divider and integer square root, one bit a cycle
module pcp_divsqrt
  import pcp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);
  logic        busy_q, busy_d;
  logic        sqrt_q, sqrt_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [63:0] num_q, num_d, den_q, den_d, quo_q, quo_d, rem_q, rem_d;
  logic        done_q, done_d;
  logic [64:0] trial;
  logic [65:0] strial;
  logic [63:0] rsh;

  always_comb begin
    busy_d = busy_q; sqrt_d = sqrt_q; cnt_d = cnt_q; num_d = num_q;
    den_d = den_q; quo_d = quo_q; rem_d = rem_q; done_d = 1'b0;
    trial = '0; strial = '0; rsh = '0;
    if (req_i.start) begin
      busy_d = 1'b1; sqrt_d = req_i.is_sqrt; num_d = req_i.num;
      den_d = req_i.den; quo_d = '0; rem_d = '0;
      cnt_d = req_i.is_sqrt ? 7'd32 : 7'd64;
    end else if (busy_q) begin
      if (!sqrt_q) begin
        trial = {rem_q, num_q[63]};
        num_d = {num_q[62:0], 1'b0};
        if (trial >= {1'b0, den_q}) begin
          rem_d = 64'(trial - {1'b0, den_q}); quo_d = {quo_q[62:0], 1'b1};
        end else begin
          rem_d = trial[63:0]; quo_d = {quo_q[62:0], 1'b0};
        end
      end else begin
        rsh = {rem_q[61:0], num_q[63:62]};
        num_d = {num_q[61:0], 2'b00};
        strial = {quo_q, 2'b01};
        if ({2'b00, rsh} >= strial) begin
          rem_d = 64'({2'b00, rsh} - strial); quo_d = {quo_q[62:0], 1'b1};
        end else begin
          rem_d = rsh; quo_d = {quo_q[62:0], 1'b0};
        end
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0; sqrt_q <= 1'b0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d; sqrt_q <= sqrt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d; den_q <= den_d; quo_q <= quo_d; rem_q <= rem_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;
  assign rsp_o.rem  = rem_q;
endmodule

FILE: hw/rtl/pcp_seq.sv
// per-vertex sequencer and polyline state, driving the shared divide / root unit
module pcp_seq
  import pcp_pkg::*;
#(
  parameter int unsigned COORD_FRAC_BITS = CoordFracBitsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic signed [CoordW-1:0] qx_i,
  input  logic signed [CoordW-1:0] qy_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  vertex_t                  in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output result_t                  out_data_o,
  output div_req_t                 div_req_o,
  input  div_rsp_t                 div_rsp_i
);
  localparam int unsigned FF = 2 * COORD_FRAC_BITS;
  localparam longint unsigned Scale = 64'd1 << FF;
  localparam longint unsigned ThrRaw = (Scale + 64'd99999999) / 64'd100000000;
  localparam logic [63:0] LenThr = (ThrRaw == 0) ? 64'd1 : 64'(ThrRaw);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_LOAD  = 12'b000000000010,
    S_SEG   = 12'b000000000100,
    S_TDIV  = 12'b000000001000,
    S_CPT   = 12'b000000010000,
    S_SQRT  = 12'b000000100000,
    S_TXDIV = 12'b000001000000,
    S_TYDIV = 12'b000010000000,
    S_UPD   = 12'b000100000000,
    S_EREQ  = 12'b001000000000,
    S_EDIV  = 12'b010000000000,
    S_OUT   = 12'b100000000000
  } state_e;

  state_e state_q, state_d;
  logic signed [CoordW-1:0] px_q, py_q, bx_q, by_q;
  logic [1:0] seen_q;
  logic last_q;
  logic [ArcW-1:0] tot_q, arc_q;
  logic [DistW-1:0] bd_q;
  logic signed [CoordW-1:0] bpx_q, bpy_q;
  logic signed [DirW-1:0] bdx_q, bdy_q;
  logic first_q;
  logic signed [CoordW:0] dx_q, dy_q;
  logic [63:0] lsq_q, dot_q;
  logic dotpos_q, degen_q;
  logic [16:0] t_q;
  logic signed [CoordW-1:0] cx_q, cy_q;
  logic [63:0] lq_q;
  logic signed [DirW-1:0] tx_q, ty_q;
  result_t res_q;
  logic out_v_q;

  div_req_t req;

  // combinational helpers (products, roundings and sums), registered where they are used
  logic signed [49:0] sqx, sqy;
  logic signed [50:0] dpx, dpy;
  logic signed [42:0] mx, my;
  logic [42:0] mxm, mym;
  logic [42:0] rqx, rqy;
  logic signed [CoordW+1:0] ex, ey;
  logic signed [51:0] ex2, ey2;
  logic [51:0] d2;
  logic [25:0] segl;
  logic [42:0] segt, st;
  logic [ArcW:0] arcsum, totsum;
  logic [DistW-1:0] dsat;
  logic signed [63:0] tmag;
  logic [63:0] dq;

  assign sqx  = dx_q * dx_q;
  assign sqy  = dy_q * dy_q;
  assign dpx  = (26'(qx_i) - 26'(px_q)) * dx_q;
  assign dpy  = (26'(qy_i) - 26'(py_q)) * dy_q;
  assign mx   = dx_q * $signed({1'b0, t_q});
  assign my   = dy_q * $signed({1'b0, t_q});
  assign mxm  = mx[42] ? 43'(-mx) : 43'(mx);
  assign mym  = my[42] ? 43'(-my) : 43'(my);
  assign rqx  = (mxm + 43'd32768) >> 16;
  assign rqy  = (mym + 43'd32768) >> 16;
  assign ex   = 26'(qx_i) - 26'(cx_q);
  assign ey   = 26'(qy_i) - 26'(cy_q);
  assign ex2  = ex * ex;
  assign ey2  = ey * ey;
  assign d2   = ex2 + ey2;
  assign dsat = (d2 > 52'(DistMax)) ? DistMax : d2[DistW-1:0];
  assign segl = 26'((lq_q + 64'd32) >> 6);
  assign segt = segl * t_q;
  assign st   = (segt + 43'd32768) >> 16;
  assign arcsum = {1'b0, tot_q} + 41'(st);
  assign totsum = {1'b0, tot_q} + 41'(segl);
  assign dq   = div_rsp_i.quo + ((div_rsp_i.rem >= (lq_q - (lq_q >> 1))) ? 64'd1 : 64'd0);

  always_comb begin
    state_d = state_q;
    req = '0;
    tmag = '0;
    case (state_q)
      S_IDLE: if (in_valid_i && !out_v_q) state_d = S_LOAD;
      S_LOAD: state_d = S_SEG;
      S_SEG: begin
        if (seen_q == 2'd0) state_d = S_UPD;
        else if (lsq_q < LenThr) state_d = S_CPT;
        else if (!dotpos_q) state_d = S_CPT;
        else if (dot_q >= lsq_q) state_d = S_CPT;
        else begin
          req.start = 1'b1; req.num = dot_q << 15; req.den = lsq_q;
          state_d = S_TDIV;
        end
      end
      S_TDIV: if (div_rsp_i.done) state_d = S_CPT;
      S_CPT: begin
        if (lsq_q != 0) begin
          req.start = 1'b1; req.is_sqrt = 1'b1; req.num = lsq_q << 12;
        end
        state_d = (lsq_q != 0) ? S_SQRT : S_UPD;
      end
      S_SQRT: if (div_rsp_i.done) begin
        if (degen_q) state_d = S_UPD;
        else begin
          req.start = 1'b1;
          tmag = dx_q[CoordW] ? -64'(dx_q) : 64'(dx_q);
          req.num = 64'(tmag) << 20; req.den = div_rsp_i.quo;
          state_d = S_TXDIV;
        end
      end
      S_TXDIV: if (div_rsp_i.done) begin
        req.start = 1'b1;
        tmag = dy_q[CoordW] ? -64'(dy_q) : 64'(dy_q);
        req.num = 64'(tmag) << 20; req.den = lq_q;
        state_d = S_TYDIV;
      end
      S_TYDIV: if (div_rsp_i.done) state_d = S_UPD;
      S_UPD: state_d = last_q ? S_EREQ : S_IDLE;
      S_EREQ: begin
        if (seen_q == 2'd2 && tot_q != 0) begin
          req.start = 1'b1; req.num = 64'(arc_q) << 16; req.den = 64'(tot_q);
          state_d = S_EDIV;
        end else state_d = S_OUT;
      end
      S_EDIV: if (div_rsp_i.done) state_d = S_OUT;
      S_OUT: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // rounded quotient with sign, clamped to the unit range
  function automatic logic signed [DirW-1:0] dir_clamp(input logic [63:0] q, input logic neg);
    logic [63:0] m;
    begin
      m = (q > 64'd16384) ? 64'd16384 : q;
      dir_clamp = neg ? -DirW'(m) : DirW'(m);
    end
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; seen_q <= '0; out_v_q <= 1'b0;
      px_q <= '0; py_q <= '0; tot_q <= '0; bd_q <= DistMax;
      bpx_q <= '0; bpy_q <= '0; bdx_q <= OneDir; bdy_q <= '0; arc_q <= '0;
    end else begin
      state_q <= state_d;
      if (out_v_q && out_ready_i) out_v_q <= 1'b0;
      case (state_q)
        S_IDLE: if (in_valid_i && !out_v_q) begin
          bx_q <= in_data_i.vertex_x; by_q <= in_data_i.vertex_y;
          last_q <= in_data_i.last_vertex;
          dx_q <= 25'(in_data_i.vertex_x) - 25'(px_q);
          dy_q <= 25'(in_data_i.vertex_y) - 25'(py_q);
        end
        S_SEG: begin
          first_q <= (seen_q == 2'd1);
          t_q <= (seen_q != 2'd0 && lsq_q >= LenThr && dotpos_q && dot_q >= lsq_q)
              ? 17'd65536 : '0;
          cx_q <= px_q; cy_q <= py_q; tx_q <= OneDir; ty_q <= '0;
          lq_q <= '0;
          degen_q <= (64'(sqx) + 64'(sqy)) < LenThr;
        end
        default: ;
      endcase
      if (state_q == S_TDIV && div_rsp_i.done)
        t_q <= {div_rsp_i.quo[15:0], ({div_rsp_i.rem[62:0], 1'b0} >= lsq_q)};
      if (state_q == S_CPT && !degen_q) begin
        cx_q <= px_q + (mx[42] ? -CoordW'(rqx) : CoordW'(rqx));
        cy_q <= py_q + (my[42] ? -CoordW'(rqy) : CoordW'(rqy));
      end
      if (state_q == S_SQRT && div_rsp_i.done) lq_q <= div_rsp_i.quo;
      if (state_q == S_TXDIV && div_rsp_i.done) tx_q <= dir_clamp(dq, dx_q[CoordW]);
      if (state_q == S_TYDIV && div_rsp_i.done) ty_q <= dir_clamp(dq, dy_q[CoordW]);
      if (state_q == S_UPD) begin
        px_q <= bx_q; py_q <= by_q;
        if (seen_q != 2'd2) seen_q <= seen_q + 2'd1;
        if (seen_q != 2'd0) begin
          if (first_q || dsat < bd_q) begin
            bd_q <= dsat; bpx_q <= cx_q; bpy_q <= cy_q; bdx_q <= tx_q; bdy_q <= ty_q;
            arc_q <= arcsum[ArcW] ? ArcMax : arcsum[ArcW-1:0];
          end
          tot_q <= totsum[ArcW] ? ArcMax : totsum[ArcW-1:0];
        end
        res_q.edge_param <= '0;
      end
      if (state_q == S_EDIV && div_rsp_i.done)
        res_q.edge_param <= (div_rsp_i.quo + ((div_rsp_i.rem >= 64'(tot_q) - (64'(tot_q) >> 1))
            ? 64'd1 : 64'd0)) > 64'd65536 ? 17'd65536 :
            17'(div_rsp_i.quo + ((div_rsp_i.rem >= 64'(tot_q) - (64'(tot_q) >> 1)) ? 64'd1 : 64'd0));
      if (state_q == S_OUT) begin
        out_v_q <= 1'b1;
        res_q.found <= (seen_q == 2'd2);
        res_q.closest_x <= (seen_q == 2'd2) ? bpx_q : '0;
        res_q.closest_y <= (seen_q == 2'd2) ? bpy_q : '0;
        res_q.tangent_x <= (seen_q == 2'd2) ? bdx_q : '0;
        res_q.tangent_y <= (seen_q == 2'd2) ? bdy_q : '0;
        res_q.distance_sq <= (seen_q == 2'd2) ? bd_q : DistMax;
        px_q <= '0; py_q <= '0; seen_q <= '0; tot_q <= '0; bd_q <= DistMax;
        bpx_q <= '0; bpy_q <= '0; bdx_q <= OneDir; bdy_q <= '0; arc_q <= '0;
      end
    end
  end

  // segment setup products, registered during S_LOAD for use in S_SEG
  always_ff @(posedge clk_i) begin
    lsq_q    <= 64'(sqx) + 64'(sqy);
    dotpos_q <= ($signed(51'(dpx)) + $signed(51'(dpy))) > 0;
    dot_q    <= 64'($signed(52'(dpx) + 52'(dpy)));
  end

  assign in_ready_o  = (state_q == S_IDLE) && !out_v_q;
  assign out_valid_o = out_v_q;
  assign out_data_o  = res_q;
  assign div_req_o   = req;
endmodule

FILE: hw/rtl/pcp_checker.sv
// port-level checks for the polyline closest point block
module pcp_checker
  import pcp_pkg::*;
(
  input logic    clk_i,
  input logic    rst_ni,
  input logic    in_valid,
  input logic    in_ready,
  input logic    out_valid,
  input logic    out_ready,
  input result_t out_data
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("out word dropped");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready) else $error("ready while busy");
  a_notfound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_data.found |-> out_data.distance_sq == DistMax)
    else $error("bad empty result");
  a_param: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> out_data.edge_param <= 17'd65536) else $error("param range");
endmodule

bind polyline_closest_point pcp_checker u_chk (
  .clk_i, .rst_ni, .in_valid(in_if.valid), .in_ready(in_if.ready),
  .out_valid(out_if.valid), .out_ready(out_if.ready), .out_data(out_if.data)
);
